>>> sv/message_dedup_table_assert.svh
// assertion macros used by the checker file of the dedup table
// no dependencies; expects clk and rst in the using scope
`ifndef MESSAGE_DEDUP_TABLE_ASSERT_SVH
`define MESSAGE_DEDUP_TABLE_ASSERT_SVH

// checked outside reset only
`define MDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define MDT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mdt_pkg.sv
// shared types, codes and constants of the message dedup table
// no dependencies
package mdt_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int KEY_BITS_DEF = 64;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 3;
  localparam int KEY_W        = 64;
  localparam int TIME_W       = 32;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE        = 3'd0,
    OP_RESTORE        = 3'd1,
    OP_MARK_DURABLE   = 3'd2,
    OP_MARK_PRESENTED = 3'd3,
    OP_MARK_ACK_SENT  = 3'd4,
    OP_FIND           = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_DUP         = 3'd1,
    ST_BAD_KEY     = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_NOT_DURABLE = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } sts_t;

  typedef struct packed {
    status_t           status;
    logic              do_present;
    logic              do_ack;
    logic              hit_durable;
    logic              hit_delivered;
    logic              hit_ack_pending;
    logic [TIME_W-1:0] hit_time_ms;
  } rsp_t;

endpackage

>>> sv/mdt_req_if.sv
// request channel of the dedup table: valid/ready plus one operation
// depends on mdt_pkg
interface mdt_req_if;
  logic                          valid;
  logic                          ready;
  logic [mdt_pkg::OP_W-1:0]      op;
  logic [mdt_pkg::KEY_W-1:0]     key;
  logic [mdt_pkg::TIME_W-1:0]    time_ms;
  logic                          restore_delivered;
  logic                          restore_ack_pending;

  modport source (
    output valid, op, key, time_ms, restore_delivered, restore_ack_pending,
    input  ready
  );
  modport sink (
    input  valid, op, key, time_ms, restore_delivered, restore_ack_pending,
    output ready
  );
endinterface

>>> sv/mdt_rsp_if.sv
// response channel of the dedup table: valid/ready plus one result
// depends on mdt_pkg
interface mdt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mdt_pkg::STATUS_W-1:0]  status;
  logic                          do_present;
  logic                          do_ack;
  logic                          hit_durable;
  logic                          hit_delivered;
  logic                          hit_ack_pending;
  logic [mdt_pkg::TIME_W-1:0]    hit_time_ms;

  modport source (
    output valid, status, do_present, do_ack, hit_durable, hit_delivered,
           hit_ack_pending, hit_time_ms,
    input  ready
  );
  modport sink (
    input  valid, status, do_present, do_ack, hit_durable, hit_delivered,
           hit_ack_pending, hit_time_ms,
    output ready
  );
endinterface

>>> sv/message_dedup_table.sv
// message dedup table: a transaction is captured when accepted and executed in
// the EXEC state once the output is not stalled, which registers its result; a
// new transaction is not accepted until the previous one has executed.
// all slot keys are matched in parallel in the accept cycle.
// synchronous reset empties the table and drops any pending result.
module message_dedup_table #(
  parameter int ENTRIES  = mdt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = mdt_pkg::KEY_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  mdt_req_if.sink   req,
  mdt_rsp_if.source rsp
);

  mdt_pkg::cmd_t cmd;
  mdt_pkg::sts_t sts;
  mdt_pkg::rsp_t rsp_data;

  mdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mdt_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk                     (clk),
    .rst                     (rst),
    .cmd                     (cmd),
    .sts                     (sts),
    .req_op                  (req.op),
    .req_key                 (req.key),
    .req_time_ms             (req.time_ms),
    .req_restore_delivered   (req.restore_delivered),
    .req_restore_ack_pending (req.restore_ack_pending),
    .rsp_valid               (rsp.valid),
    .rsp_ready               (rsp.ready),
    .rsp_data                (rsp_data)
  );

  assign rsp.status          = rsp_data.status;
  assign rsp.do_present      = rsp_data.do_present;
  assign rsp.do_ack          = rsp_data.do_ack;
  assign rsp.hit_durable     = rsp_data.hit_durable;
  assign rsp.hit_delivered   = rsp_data.hit_delivered;
  assign rsp.hit_ack_pending = rsp_data.hit_ack_pending;
  assign rsp.hit_time_ms     = rsp_data.hit_time_ms;

endmodule

>>> sv/mdt_ctrl.sv
// controller of the dedup table: accept, then execute once the output is free
// depends on mdt_pkg
module mdt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mdt_pkg::sts_t sts,
  output mdt_pkg::cmd_t cmd
);

  mdt_pkg::state_t state;
  mdt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mdt_pkg::S_IDLE: begin
        if (req_valid) state_next = mdt_pkg::S_EXEC;
      end
      mdt_pkg::S_EXEC: begin
        if (!sts.out_stall) state_next = mdt_pkg::S_IDLE;
      end
      default: state_next = mdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      mdt_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      mdt_pkg::S_EXEC: begin
        cmd.exec = !sts.out_stall;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/mdt_datapath.sv
// datapath of the dedup table: slot registers, parallel key match, flag update
// and the output register; depends on mdt_pkg
module mdt_datapath #(
  parameter int ENTRIES  = mdt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = mdt_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mdt_pkg::cmd_t                 cmd,
  output mdt_pkg::sts_t                 sts,
  input  logic [mdt_pkg::OP_W-1:0]      req_op,
  input  logic [mdt_pkg::KEY_W-1:0]     req_key,
  input  logic [mdt_pkg::TIME_W-1:0]    req_time_ms,
  input  logic                          req_restore_delivered,
  input  logic                          req_restore_ack_pending,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output mdt_pkg::rsp_t                 rsp_data
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);

  // slot state
  logic [ENTRIES-1:0]               slot_used;
  logic [KEY_BITS-1:0]              slot_key         [ENTRIES];
  logic [mdt_pkg::TIME_W-1:0]       slot_time        [ENTRIES];
  logic                             slot_durable     [ENTRIES];
  logic                             slot_delivered   [ENTRIES];
  logic                             slot_ack_pending [ENTRIES];
  logic [CNTW-1:0]                  used_count;

  // captured transaction and match result
  logic [mdt_pkg::OP_W-1:0]         op_q;
  logic [KEY_BITS-1:0]              key_q;
  logic [mdt_pkg::TIME_W-1:0]       time_q;
  logic                             rd_q;
  logic                             ra_q;
  logic                             key_ok_q;
  logic                             found_q;
  logic [IDXW-1:0]                  hit_idx_q;

  logic [KEY_BITS-1:0]              key_in;
  logic [ENTRIES-1:0]               hit_vec;
  logic [IDXW-1:0]                  hit_idx;

  logic [IDXW-1:0]                  free_idx;
  logic [IDXW-1:0]                  wr_idx;
  logic                             full;
  logic                             cur_dur;
  logic                             cur_del;
  logic                             cur_ack;
  logic                             alloc;
  logic                             upd;
  logic                             new_dur;
  logic                             new_del;
  logic                             new_ack;
  mdt_pkg::rsp_t                    res;

  assign key_in = req_key[KEY_BITS-1:0];

  // parallel match against all in-use slots; keys are unique in the table
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = slot_used[i] && (slot_key[i] == key_in);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_idx = hit_idx | (hit_vec[i] ? IDXW'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= req_op;
      key_q     <= key_in;
      time_q    <= req_time_ms;
      rd_q      <= req_restore_delivered;
      ra_q      <= req_restore_ack_pending;
      key_ok_q  <= (key_in != '0);
      found_q   <= (|hit_vec) && (key_in != '0);
      hit_idx_q <= hit_idx;
    end
  end

  // slots fill from the bottom and are never freed
  assign free_idx = used_count[IDXW-1:0];
  assign full     = (used_count == CNTW'(ENTRIES));
  assign cur_dur  = slot_durable[hit_idx_q];
  assign cur_del  = slot_delivered[hit_idx_q];
  assign cur_ack  = slot_ack_pending[hit_idx_q];
  assign wr_idx   = alloc ? free_idx : hit_idx_q;

  always_comb begin
    res        = '0;
    res.status = mdt_pkg::ST_BAD_KEY;
    alloc      = 1'b0;
    upd        = 1'b0;
    new_dur    = cur_dur;
    new_del    = cur_del;
    new_ack    = cur_ack;
    unique case (op_q)
      mdt_pkg::OP_RECEIVE: begin
        if (key_ok_q) begin
          if (found_q) begin
            res.status = mdt_pkg::ST_DUP;
            if (cur_dur) begin
              res.do_present = !cur_del;
              res.do_ack     = 1'b1;
              upd            = 1'b1;
              new_ack        = 1'b1;
            end
          end else if (full) begin
            res.status = mdt_pkg::ST_FULL;
          end else begin
            res.status = mdt_pkg::ST_OK;
            alloc      = 1'b1;
            new_dur    = 1'b0;
            new_del    = 1'b0;
            new_ack    = 1'b1;
          end
        end
      end
      mdt_pkg::OP_RESTORE: begin
        if (key_ok_q) begin
          if (found_q) begin
            res.status = mdt_pkg::ST_DUP;
            upd        = 1'b1;
            new_dur    = 1'b1;
            new_del    = cur_del | rd_q;
            new_ack    = cur_ack | ra_q;
          end else if (full) begin
            res.status = mdt_pkg::ST_FULL;
          end else begin
            res.status = mdt_pkg::ST_OK;
            alloc      = 1'b1;
            new_dur    = 1'b1;
            new_del    = rd_q;
            new_ack    = ra_q;
          end
        end
      end
      mdt_pkg::OP_MARK_DURABLE: begin
        if (key_ok_q) begin
          if (found_q) begin
            res.status     = mdt_pkg::ST_OK;
            res.do_present = !cur_del;
            res.do_ack     = cur_ack;
            upd            = 1'b1;
            new_dur        = 1'b1;
          end else begin
            res.status = mdt_pkg::ST_NOT_FOUND;
          end
        end
      end
      mdt_pkg::OP_MARK_PRESENTED, mdt_pkg::OP_MARK_ACK_SENT: begin
        if (key_ok_q) begin
          if (!found_q) begin
            res.status = mdt_pkg::ST_NOT_FOUND;
          end else if (!cur_dur) begin
            res.status = mdt_pkg::ST_NOT_DURABLE;
          end else begin
            res.status = mdt_pkg::ST_OK;
            upd        = 1'b1;
            if (op_q == mdt_pkg::OP_MARK_PRESENTED) new_del = 1'b1;
            else                                     new_ack = 1'b0;
          end
        end
      end
      mdt_pkg::OP_FIND: begin
        if (found_q) begin
          res.status          = mdt_pkg::ST_OK;
          res.hit_durable     = cur_dur;
          res.hit_delivered   = cur_del;
          res.hit_ack_pending = cur_ack;
          res.hit_time_ms     = slot_time[hit_idx_q];
        end else begin
          res.status = mdt_pkg::ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used  <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.exec && alloc) begin
        slot_used[free_idx] <= 1'b1;
        used_count          <= used_count + CNTW'(1);
      end
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && alloc) begin
      slot_key[free_idx]  <= key_q;
      slot_time[free_idx] <= time_q;
    end
    if (cmd.exec && (alloc || upd)) begin
      slot_durable[wr_idx]     <= new_dur;
      slot_delivered[wr_idx]   <= new_del;
      slot_ack_pending[wr_idx] <= new_ack;
    end
    if (cmd.exec) begin
      rsp_data <= res;
    end
  end

  assign sts.out_stall = rsp_valid && !rsp_ready;

endmodule

>>> sv/mdt_checker.sv
// port-level checks of the message dedup table and the bind that attaches them
// depends on mdt_pkg and message_dedup_table_assert.svh
`include "message_dedup_table_assert.svh"

module mdt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [mdt_pkg::STATUS_W-1:0]  rsp_status,
  input logic                          rsp_do_present,
  input logic                          rsp_do_ack,
  input logic                          rsp_hit_durable,
  input logic                          rsp_hit_delivered,
  input logic                          rsp_hit_ack_pending,
  input logic [mdt_pkg::TIME_W-1:0]    rsp_hit_time_ms
);

  logic                                          rsp_stalled;
  logic                                          hit_any;
  logic                                          action_any;
  logic                                          status_ok;
  logic                                          status_ok_dup;
  logic [mdt_pkg::STATUS_W+mdt_pkg::TIME_W+4:0]  rsp_word;

  assign rsp_stalled   = rsp_valid && !rsp_ready;
  assign hit_any       = rsp_hit_durable || rsp_hit_delivered || rsp_hit_ack_pending ||
                         (rsp_hit_time_ms != '0);
  assign action_any    = rsp_do_present || rsp_do_ack;
  assign status_ok     = (rsp_status == mdt_pkg::ST_OK);
  assign status_ok_dup = status_ok || (rsp_status == mdt_pkg::ST_DUP);
  assign rsp_word      = {rsp_status, rsp_do_present, rsp_do_ack, rsp_hit_durable,
                          rsp_hit_delivered, rsp_hit_ack_pending, rsp_hit_time_ms};

  // one transaction in flight: no accept right after an accept
  `MDT_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "accept while busy")

  `MDT_ASSERT(a_rsp_hold, rsp_stalled |=> rsp_valid && $stable(rsp_word), "stalled result changed")

  // hit fields only carry data on a successful find
  `MDT_ASSERT(a_hit_zero, rsp_valid && !status_ok |-> !hit_any, "hit fields set without a hit")

  `MDT_ASSERT(a_action_status, rsp_valid && action_any |-> status_ok_dup, "action on a failure")

  `MDT_ASSERT_RST(a_reset_drops, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind message_dedup_table mdt_checker u_mdt_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_do_present      (rsp.do_present),
  .rsp_do_ack          (rsp.do_ack),
  .rsp_hit_durable     (rsp.hit_durable),
  .rsp_hit_delivered   (rsp.hit_delivered),
  .rsp_hit_ack_pending (rsp.hit_ack_pending),
  .rsp_hit_time_ms     (rsp.hit_time_ms)
);

>>> verif/message_dedup_table_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of message_dedup_table: directed and random operations,
// predicted by a behavioral copy of the table; depends on mdt_pkg, mdt_req_if, mdt_rsp_if
module message_dedup_table_tb;

  localparam int ENTRIES     = mdt_pkg::ENTRIES_DEF;
  localparam int KEY_BITS    = mdt_pkg::KEY_BITS_DEF;
  localparam logic [mdt_pkg::KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= mdt_pkg::KEY_W) ? {mdt_pkg::KEY_W{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [mdt_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [mdt_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int POOL_N      = 36;
  localparam int HOLD_CYCLES = 200;
  localparam int STUCK_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [mdt_pkg::OP_W-1:0]   op;
    logic [mdt_pkg::KEY_W-1:0]  key;
    logic [mdt_pkg::TIME_W-1:0] time_ms;
    logic                       rd;
    logic                       ra;
  } dedup_req_t;

  logic clk;
  logic rst = 1'b1;

  mdt_req_if req_ch ();
  mdt_rsp_if rsp_ch ();

  message_dedup_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dedup_req_t    pend_q [$];
  mdt_pkg::rsp_t result_q [$];
  int mismatches   = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stuck_cycles = 0;
  logic [mdt_pkg::KEY_W-1:0] key_pool [POOL_N];

  // shadow copy of the table
  bit                         tbl_used      [ENTRIES];
  logic [mdt_pkg::KEY_W-1:0]  tbl_key       [ENTRIES];
  logic [mdt_pkg::TIME_W-1:0] tbl_time      [ENTRIES];
  bit                         tbl_durable   [ENTRIES];
  bit                         tbl_delivered [ENTRIES];
  bit                         tbl_ackp      [ENTRIES];
  int                         tbl_count = 0;

  initial begin
    clk = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = '0;
    req_ch.key = '0;
    req_ch.time_ms = '0;
    req_ch.restore_delivered = 1'b0;
    req_ch.restore_ack_pending = 1'b0;
    rsp_ch.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  // lowest free slot, filled with the new key, or -1 when full
  function automatic int grab_slot(logic [mdt_pkg::KEY_W-1:0] k,
                                   logic [mdt_pkg::TIME_W-1:0] t);
    int i;
    if (tbl_count >= ENTRIES) return -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (!tbl_used[i]) begin
        tbl_used[i] = 1'b1;
        tbl_key[i] = k;
        tbl_time[i] = t;
        tbl_durable[i] = 1'b0;
        tbl_delivered[i] = 1'b0;
        tbl_ackp[i] = 1'b0;
        tbl_count++;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic mdt_pkg::rsp_t table_apply(dedup_req_t it);
    mdt_pkg::rsp_t r;
    logic [mdt_pkg::KEY_W-1:0] k;
    bit ok_key;
    int s;
    int i;
    r = '0;
    r.status = mdt_pkg::ST_BAD_KEY;
    k = it.key & KEY_MASK;
    ok_key = (k != '0);
    s = -1;
    if (it.op <= mdt_pkg::OP_FIND && ok_key) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (s < 0 && tbl_used[i] && tbl_key[i] == k) s = i;
      end
    end
    case (it.op)
      mdt_pkg::OP_RECEIVE: begin
        if (ok_key) begin
          if (s >= 0) begin
            r.status = mdt_pkg::ST_DUP;
            if (tbl_durable[s]) begin
              r.do_present = !tbl_delivered[s];
              r.do_ack = 1'b1;
              tbl_ackp[s] = 1'b1;
            end
          end else begin
            s = grab_slot(k, it.time_ms);
            if (s < 0) begin
              r.status = mdt_pkg::ST_FULL;
            end else begin
              tbl_ackp[s] = 1'b1;
              r.status = mdt_pkg::ST_OK;
            end
          end
        end
      end
      mdt_pkg::OP_RESTORE: begin
        if (ok_key) begin
          if (s >= 0) begin
            tbl_durable[s] = 1'b1;
            tbl_delivered[s] = tbl_delivered[s] | it.rd;
            tbl_ackp[s] = tbl_ackp[s] | it.ra;
            r.status = mdt_pkg::ST_DUP;
          end else begin
            s = grab_slot(k, it.time_ms);
            if (s < 0) begin
              r.status = mdt_pkg::ST_FULL;
            end else begin
              tbl_durable[s] = 1'b1;
              tbl_delivered[s] = it.rd;
              tbl_ackp[s] = it.ra;
              r.status = mdt_pkg::ST_OK;
            end
          end
        end
      end
      mdt_pkg::OP_MARK_DURABLE: begin
        if (ok_key) begin
          if (s < 0) begin
            r.status = mdt_pkg::ST_NOT_FOUND;
          end else begin
            tbl_durable[s] = 1'b1;
            r.do_present = !tbl_delivered[s];
            r.do_ack = tbl_ackp[s];
            r.status = mdt_pkg::ST_OK;
          end
        end
      end
      mdt_pkg::OP_MARK_PRESENTED, mdt_pkg::OP_MARK_ACK_SENT: begin
        if (ok_key) begin
          if (s < 0) begin
            r.status = mdt_pkg::ST_NOT_FOUND;
          end else if (!tbl_durable[s]) begin
            r.status = mdt_pkg::ST_NOT_DURABLE;
          end else begin
            if (it.op == mdt_pkg::OP_MARK_PRESENTED) tbl_delivered[s] = 1'b1;
            else tbl_ackp[s] = 1'b0;
            r.status = mdt_pkg::ST_OK;
          end
        end
      end
      mdt_pkg::OP_FIND: begin
        if (s < 0) begin
          r.status = mdt_pkg::ST_NOT_FOUND;
        end else begin
          r.hit_durable = tbl_durable[s];
          r.hit_delivered = tbl_delivered[s];
          r.hit_ack_pending = tbl_ackp[s];
          r.hit_time_ms = tbl_time[s];
          r.status = mdt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [mdt_pkg::KEY_W-1:0] rnd_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic rnd_bit();
    logic [31:0] v;
    v = $urandom_range(1);
    return v[0];
  endfunction

  function automatic logic [mdt_pkg::OP_W-1:0] rnd_op();
    logic [31:0] v;
    v = $urandom_range(7);
    return v[mdt_pkg::OP_W-1:0];
  endfunction

  task automatic push_op(logic [mdt_pkg::OP_W-1:0] op, logic [mdt_pkg::KEY_W-1:0] key,
                         logic [mdt_pkg::TIME_W-1:0] t, logic rd, logic ra);
    dedup_req_t it;
    it.op = op;
    it.key = key;
    it.time_ms = t;
    it.rd = rd;
    it.ra = ra;
    pend_q.push_back(it);
  endtask

  // mostly full message lifecycles on pooled keys, the rest noise
  task automatic queue_random(int n);
    int start;
    logic [mdt_pkg::KEY_W-1:0] k;
    int pick;
    start = pend_q.size();
    while (pend_q.size() - start < n) begin
      if ($urandom_range(99) < 65) begin
        k = key_pool[$urandom_range(POOL_N - 1)];
        if ($urandom_range(1))
          push_op(mdt_pkg::OP_RECEIVE, k, $urandom(), rnd_bit(), rnd_bit());
        else
          push_op(mdt_pkg::OP_RESTORE, k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 30)
          push_op(mdt_pkg::OP_RECEIVE, k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 25)
          push_op($urandom_range(1) ? mdt_pkg::OP_MARK_PRESENTED : mdt_pkg::OP_MARK_ACK_SENT,
                  k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 75)
          push_op(mdt_pkg::OP_MARK_DURABLE, k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 40)
          push_op(mdt_pkg::OP_RECEIVE, k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 60)
          push_op(mdt_pkg::OP_MARK_PRESENTED, k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 60)
          push_op(mdt_pkg::OP_MARK_ACK_SENT, k, $urandom(), rnd_bit(), rnd_bit());
        if ($urandom_range(99) < 80)
          push_op(mdt_pkg::OP_FIND, k, $urandom(), rnd_bit(), rnd_bit());
      end else begin
        pick = $urandom_range(99);
        if (pick < 20) k = '0;
        else if (pick < 75) k = key_pool[$urandom_range(POOL_N - 1)];
        else k = rnd_key();
        push_op(rnd_op(), k, $urandom(), rnd_bit(), rnd_bit());
      end
    end
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // request driver: a pending transaction stays on the bus until taken
  always @(posedge clk) begin : req_drive
    bit holding;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      holding = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        result_q.push_back(table_apply(pend_q[0]));
        void'(pend_q.pop_front());
      end else begin
        holding = req_ch.valid;
      end
      if (!holding) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          req_ch.valid <= 1'b1;
          req_ch.op <= pend_q[0].op;
          req_ch.key <= pend_q[0].key;
          req_ch.time_ms <= pend_q[0].time_ms;
          req_ch.restore_delivered <= pend_q[0].rd;
          req_ch.restore_ack_pending <= pend_q[0].ra;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : rsp_check
    mdt_pkg::rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transaction, status %0d", rsp_ch.status);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_ch.status));
        check_field("do_present", 64'(want.do_present), 64'(rsp_ch.do_present));
        check_field("do_ack", 64'(want.do_ack), 64'(rsp_ch.do_ack));
        check_field("hit_durable", 64'(want.hit_durable), 64'(rsp_ch.hit_durable));
        check_field("hit_delivered", 64'(want.hit_delivered), 64'(rsp_ch.hit_delivered));
        check_field("hit_ack_pending", 64'(want.hit_ack_pending),
                    64'(rsp_ch.hit_ack_pending));
        check_field("hit_time_ms", 64'(want.hit_time_ms), 64'(rsp_ch.hit_time_ms));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int i;
    key_pool[0] = {mdt_pkg::KEY_W{1'b1}};
    key_pool[1] = 64'd1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    for (i = 3; i < POOL_N; i++) begin
      key_pool[i] = rnd_key();
      if (key_pool[i] == '0) key_pool[i] = 64'h5a5a;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // invalid key on every op, undefined ops, lookups on an empty table
    push_op(mdt_pkg::OP_FIND, '0, '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_RECEIVE, '0, '1, 1'b1, 1'b1);
    push_op(mdt_pkg::OP_RESTORE, '0, '1, 1'b1, 1'b1);
    push_op(mdt_pkg::OP_MARK_DURABLE, '0, '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_PRESENTED, '0, '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_ACK_SENT, '0, '0, 1'b0, 1'b0);
    push_op(OP_RSVD_6, key_pool[0], '1, 1'b1, 1'b1);
    push_op(OP_RSVD_7, key_pool[0], '1, 1'b1, 1'b1);
    push_op(mdt_pkg::OP_MARK_DURABLE, key_pool[1], '0, 1'b0, 1'b0);
    // one message through its whole life
    push_op(mdt_pkg::OP_RECEIVE, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_RECEIVE, key_pool[0], '1, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_PRESENTED, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_ACK_SENT, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_DURABLE, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_RECEIVE, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_PRESENTED, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_RECEIVE, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_MARK_ACK_SENT, key_pool[0], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_FIND, key_pool[0], '0, 1'b0, 1'b0);
    // restore new and existing
    push_op(mdt_pkg::OP_RESTORE, key_pool[1], '1, 1'b1, 1'b1);
    push_op(mdt_pkg::OP_RESTORE, key_pool[1], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_FIND, key_pool[1], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_RESTORE, key_pool[2], 32'h8000_0000, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_FIND, key_pool[2], '0, 1'b0, 1'b0);
    push_op(mdt_pkg::OP_FIND, key_pool[3], '0, 1'b0, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_req++;
    queue_random(95);
    wait_drained();

    tx_idle_pct = 59;
    queue_random(95);
    wait_drained();

    tx_idle_pct = 0;
    rx_stall_pct = 59;
    queue_random(95);
    wait_drained();

    tx_idle_pct = 38;
    rx_stall_pct = 38;
    queue_random(95);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
